>>> sv/rrpid_pkg.sv
// Shared types and constants for the RR peak interval detector.
package rrpid_pkg;

  localparam int HALF_WINDOW_DEF = 5;

  localparam int TIME_W = 32;
  localparam int POT_W  = 16;
  localparam int POS_W  = 5;
  localparam int RR_W   = 33;
  localparam int CFG_W  = 16;

  localparam logic signed [CFG_W-1:0] THRESHOLD_RST    = 16'sd1229;
  localparam logic        [CFG_W-1:0] MIN_INTERVAL_RST = 16'd50;

  // A rise is 1000*p[i] >= 1001*p[i-1], i.e. a growth of at least 0.1 percent.
  localparam logic signed [10:0] RISE_MUL_CUR  = 11'sd1000;
  localparam logic signed [10:0] RISE_MUL_PREV = 11'sd1001;

  typedef enum logic [0:0] {
    REG_PEAK_THRESHOLD = 1'b0,
    REG_MIN_INTERVAL   = 1'b1
  } rrpid_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_FINISH = 2'd2
  } rrpid_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } rrpid_cmd_t;

  typedef struct packed {
    logic eval;
    logic has_prev;
    logic scan_last;
    logic out_free;
  } rrpid_stat_t;

endpackage

>>> sv/rrpid_ctrl.sv
// Controller state machine: request intake, window scan sequencing and result hand-off.
module rrpid_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  rrpid_pkg::rrpid_stat_t stat_i,
  output rrpid_pkg::rrpid_cmd_t  cmd_o
);
  import rrpid_pkg::*;

  rrpid_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          // Requests at or below the threshold only update the window.
          if (stat_i.eval) begin
            state_d = stat_i.has_prev ? ST_SCAN : ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/rrpid_dp.sv
// Datapath: sample window, rise compare unit, peak bookkeeping and result register.
module rrpid_dp #(
  parameter int HALF_WINDOW = rrpid_pkg::HALF_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrpid_pkg::rrpid_cmd_t               cmd_i,
  output rrpid_pkg::rrpid_stat_t              stat_o,
  input  logic        [rrpid_pkg::TIME_W-1:0] sample_time_i,
  input  logic signed [rrpid_pkg::POT_W-1:0]  potential_i,
  input  logic                                cfg_we_i,
  input  logic        [0:0]                   cfg_index_i,
  input  logic        [rrpid_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rrpid_pkg::POS_W-1:0]  peak_position_o,
  output logic                                interval_valid_o,
  output logic        [rrpid_pkg::RR_W-1:0]   rr_interval_o
);
  import rrpid_pkg::*;

  localparam int DEPTH = 2 * HALF_WINDOW;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PROD_W = POT_W + 11;
  localparam int DIFF_W = RR_W + 1;

  logic signed [CFG_W-1:0]  thr_q;
  logic        [CFG_W-1:0]  min_q;

  logic        [TIME_W-1:0] win_t_q [DEPTH];
  logic signed [POT_W-1:0]  win_p_q [DEPTH];
  logic        [CNT_W-1:0]  fill_q;
  logic                     full;

  logic        [IDX_W-1:0]  idx_q;
  logic signed [POT_W-1:0]  prev_q;
  logic                     found_q;
  logic        [IDX_W-1:0]  pos_q;
  logic        [TIME_W-1:0] ptime_q;

  logic signed [RR_W-1:0]   last_q;
  logic signed [POS_W-1:0]  held_q;

  logic                     out_valid_q;
  logic signed [POS_W-1:0]  out_pos_q;
  logic                     out_iv_q;
  logic        [RR_W-1:0]   out_rr_q;

  logic signed [POT_W-1:0]  cur_p;
  logic signed [PROD_W-1:0] prod_cur;
  logic signed [PROD_W-1:0] prod_prev;
  logic                     rise;
  logic signed [DIFF_W-1:0] diff;
  logic                     accept_iv;
  logic signed [POS_W-1:0]  new_held;

  assign full = (fill_q == CNT_W'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      min_q <= MIN_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PEAK_THRESHOLD: thr_q <= cfg_data_i;
        REG_MIN_INTERVAL:   min_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The window fills from position zero, then shifts so the oldest sample stays at zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (full) begin
        for (int k = 0; k < DEPTH - 1; k++) begin
          win_t_q[k] <= win_t_q[k+1];
          win_p_q[k] <= win_p_q[k+1];
        end
        win_t_q[DEPTH-1] <= sample_time_i;
        win_p_q[DEPTH-1] <= potential_i;
      end else begin
        win_t_q[fill_q[IDX_W-1:0]] <= sample_time_i;
        win_p_q[fill_q[IDX_W-1:0]] <= potential_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.load && !full) begin
      fill_q <= fill_q + CNT_W'(1);
    end
  end

  assign cur_p     = win_p_q[idx_q];
  assign prod_cur  = PROD_W'(cur_p) * PROD_W'(RISE_MUL_CUR);
  assign prod_prev = PROD_W'(prev_q) * PROD_W'(RISE_MUL_PREV);
  assign rise      = (prod_cur >= prod_prev);

  // One position per cycle; prev_q carries p[i-1] from the step before.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.step && rise) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q  <= IDX_W'(1);
      prev_q <= full ? win_p_q[1] : win_p_q[0];
    end else if (cmd_i.step) begin
      idx_q  <= idx_q + IDX_W'(1);
      prev_q <= cur_p;
      if (rise) begin
        pos_q   <= idx_q;
        ptime_q <= win_t_q[idx_q];
      end
    end
  end

  assign diff = $signed({{(DIFF_W-TIME_W){1'b0}}, ptime_q}) - DIFF_W'(last_q);
  assign accept_iv = found_q && (pos_q == IDX_W'(HALF_WINDOW)) && (ptime_q != '0) &&
                     (diff > $signed({{(DIFF_W-CFG_W){1'b0}}, min_q}));
  assign new_held  = found_q ? $signed(POS_W'(pos_q)) : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '1;
      held_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        held_q      <= new_held;
        out_valid_q <= 1'b1;
        if (accept_iv) begin
          last_q <= $signed({1'b0, ptime_q});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_pos_q <= new_held;
      out_iv_q  <= accept_iv;
      out_rr_q  <= accept_iv ? diff[RR_W-1:0] : '0;
    end
  end

  assign stat_o.eval      = (potential_i > thr_q);
  assign stat_o.has_prev  = (fill_q != '0);
  assign stat_o.scan_last = (idx_q == IDX_W'(fill_q - CNT_W'(1)));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign peak_position_o  = out_pos_q;
  assign interval_valid_o = out_iv_q;
  assign rr_interval_o    = out_rr_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("window fill count exceeds depth");

  a_iv_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_iv_q |-> out_pos_q == POS_W'(HALF_WINDOW))
    else $error("interval reported away from window center");

  a_rr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_iv_q |-> out_rr_q == '0)
    else $error("interval value nonzero without flag");

  a_scan_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> CNT_W'(idx_q) < fill_q)
    else $error("scan index beyond filled window");

endmodule

>>> sv/rr_peak_interval_detector_core.sv
// Top level of the RR peak interval detector: stream ports, controller and datapath.
// A request at or below the threshold only updates the window and yields no result.
// A request above the threshold passes an intake step, n - 1 steps of the single rise
// compare unit (n being the window fill, at most 2*HALF_WINDOW) and a finish step that
// loads the output register once it is free. New requests are taken only in idle.
// Reset: thresholds return to defaults, the window empties, no peak is held.
module rr_peak_interval_detector_core #(
  parameter int HALF_WINDOW = rrpid_pkg::HALF_WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_time[31:0], potential[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // peak_position[4:0], rr_interval[37:5], zero[39:38]
  output logic        m_axis_tuser,   // interval_valid[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import rrpid_pkg::*;

  rrpid_cmd_t               cmd;
  rrpid_stat_t              stat;
  logic signed [POS_W-1:0]  peak_position;
  logic        [RR_W-1:0]   rr_interval;

  assign cfg_ready_o = 1'b1;

  rrpid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rrpid_dp #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_time_i    (s_axis_tdata[31:0]),
    .potential_i      ($signed(s_axis_tdata[47:32])),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .peak_position_o  (peak_position),
    .interval_valid_o (m_axis_tuser),
    .rr_interval_o    (rr_interval)
  );

  assign m_axis_tdata = {2'b00, rr_interval, peak_position};

endmodule
